[rtl/cnr_pkg.sv]
package cnr_pkg;

  localparam int MASK_W  = 64;
  localparam int CHUNK_W = 16;
  localparam int N_CHUNK = MASK_W / CHUNK_W;
  localparam int RANK_W  = 30;
  localparam int CNT_W   = 7;
  localparam int CHK_CW  = 5;
  localparam int BIN_K   = 8;
  localparam int ORD_W   = 3;
  localparam int N_PART4 = MASK_W / 4;
  localparam int N_PART16 = N_PART4 / 4;

  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [MASK_W-1:0][BIN_K-1:0][RANK_W-1:0] bin_tab_t;

  // Build C(n, k) for k up to 7 from Pascal's rule
  function automatic bin_tab_t bin_tab_f();
    bin_tab_t t;
    t = '0;
    for (int n = 0; n < MASK_W; n++) begin
      for (int k = 0; k < BIN_K; k++) begin
        if (k == 0) begin
          t[n][k] = RANK_W'(1);
        end else if (n == 0) begin
          t[n][k] = '0;
        end else begin
          t[n][k] = t[n-1][k-1] + t[n-1][k];
        end
      end
    end
    return t;
  endfunction

  localparam bin_tab_t BIN_TAB = bin_tab_f();

endpackage

[rtl/combinadic_rank_64bit_core.sv]
// Throughput: one beat per cycle while the output is not stalled; the six-stage chain (chunk
// popcount, chunk offsets, binomial table lookup, three adder-tree levels) carries each beat.
// Each stage holds while the one after it is full and stalled; empty stages fill.
// Reset (rst_n low, synchronous) clears every stage valid bit; payload is not reset.
module combinadic_rank_64bit_core #(
  parameter int MAX_SET = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cnr_pkg::MASK_W-1:0]  in_card_mask,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cnr_pkg::RANK_W-1:0]  out_rank,
  output logic                        out_too_many_bits,
  output logic [cnr_pkg::CNT_W-1:0]   out_bit_count
);

  localparam int NST = 6;

  logic [NST-1:0] v_r;
  logic [NST-1:0] rdy;

  // Stage payloads
  logic [cnr_pkg::MASK_W-1:0]                         s1_mask_r;
  logic [cnr_pkg::N_CHUNK-1:0][cnr_pkg::CHK_CW-1:0]   s1_cnt_r, s1_cnt_nxt;
  logic [cnr_pkg::MASK_W-1:0]                         s2_mask_r;
  logic [cnr_pkg::N_CHUNK-1:0][cnr_pkg::CNT_W-1:0]    s2_off_r, s2_off_nxt;
  cnr_pkg::cnt_t                                      s2_tot_r, s2_tot_nxt;
  logic [cnr_pkg::MASK_W-1:0][cnr_pkg::RANK_W-1:0]    s3_term_r, s3_term_nxt;
  cnr_pkg::cnt_t                                      s3_tot_r;
  logic [cnr_pkg::N_PART4-1:0][cnr_pkg::RANK_W-1:0]   s4_part_r, s4_part_nxt;
  cnr_pkg::cnt_t                                      s4_tot_r;
  logic [cnr_pkg::N_PART16-1:0][cnr_pkg::RANK_W-1:0]  s5_part_r, s5_part_nxt;
  cnr_pkg::cnt_t                                      s5_tot_r;
  cnr_pkg::rank_t                                     s6_rank_r, s6_rank_nxt;
  logic                                               s6_err_r, s6_err_nxt;
  cnr_pkg::cnt_t                                      s6_cnt_r;

  // Ready chain: a stage takes a beat when empty or when it passes its own on
  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || out_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  assign in_ready = rdy[0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int s = 1; s < NST; s++) begin
        if (rdy[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // Stage 1: count set bits per 16-bit chunk
  always_comb begin
    for (int k = 0; k < cnr_pkg::N_CHUNK; k++) begin
      s1_cnt_nxt[k] = cnr_pkg::CHK_CW'($countones(
        in_card_mask[k*cnr_pkg::CHUNK_W +: cnr_pkg::CHUNK_W]));
    end
  end

  // Stage 2: running offsets of the chunks and the total count
  always_comb begin
    s2_off_nxt[0] = '0;
    for (int k = 1; k < cnr_pkg::N_CHUNK; k++) begin
      s2_off_nxt[k] = s2_off_nxt[k-1] + cnr_pkg::CNT_W'(s1_cnt_r[k-1]);
    end
    s2_tot_nxt = s2_off_nxt[cnr_pkg::N_CHUNK-1]
               + cnr_pkg::CNT_W'(s1_cnt_r[cnr_pkg::N_CHUNK-1]);
  end

  // Stage 3: ordinal of every set bit, then its binomial term
  always_comb begin
    logic [cnr_pkg::CHUNK_W-1:0] low_m;
    cnr_pkg::cnt_t               ord;
    int                          p;
    low_m = '0;
    ord   = '0;
    p     = 0;
    for (int k = 0; k < cnr_pkg::N_CHUNK; k++) begin
      for (int j = 0; j < cnr_pkg::CHUNK_W; j++) begin
        p     = k * cnr_pkg::CHUNK_W + j;
        low_m = cnr_pkg::CHUNK_W'((33'(1) << (j + 1)) - 33'(1));
        ord   = s2_off_r[k] + cnr_pkg::CNT_W'($countones(
          s2_mask_r[k*cnr_pkg::CHUNK_W +: cnr_pkg::CHUNK_W] & low_m));
        if (s2_mask_r[p] && (ord <= cnr_pkg::CNT_W'(MAX_SET))) begin
          s3_term_nxt[p] = cnr_pkg::BIN_TAB[p][ord[cnr_pkg::ORD_W-1:0]];
        end else begin
          s3_term_nxt[p] = '0;
        end
      end
    end
  end

  // Stage 4: sum terms in groups of four
  always_comb begin
    for (int g = 0; g < cnr_pkg::N_PART4; g++) begin
      s4_part_nxt[g] = s3_term_r[4*g] + s3_term_r[4*g+1]
                     + s3_term_r[4*g+2] + s3_term_r[4*g+3];
    end
  end

  // Stage 5: sum partials in groups of four
  always_comb begin
    for (int h = 0; h < cnr_pkg::N_PART16; h++) begin
      s5_part_nxt[h] = s4_part_r[4*h] + s4_part_r[4*h+1]
                     + s4_part_r[4*h+2] + s4_part_r[4*h+3];
    end
  end

  // Stage 6: final sum plus one, drop to zero on too many bits
  always_comb begin
    cnr_pkg::rank_t sum;
    sum = cnr_pkg::RANK_W'(1);
    for (int h = 0; h < cnr_pkg::N_PART16; h++) begin
      sum = sum + s5_part_r[h];
    end
    s6_err_nxt  = (s5_tot_r > cnr_pkg::CNT_W'(MAX_SET));
    s6_rank_nxt = s6_err_nxt ? '0 : sum;
  end

  // Payload registers, each held while its stage stalls
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_mask_r <= in_card_mask;
      s1_cnt_r  <= s1_cnt_nxt;
    end
    if (rdy[1]) begin
      s2_mask_r <= s1_mask_r;
      s2_off_r  <= s2_off_nxt;
      s2_tot_r  <= s2_tot_nxt;
    end
    if (rdy[2]) begin
      s3_term_r <= s3_term_nxt;
      s3_tot_r  <= s2_tot_r;
    end
    if (rdy[3]) begin
      s4_part_r <= s4_part_nxt;
      s4_tot_r  <= s3_tot_r;
    end
    if (rdy[4]) begin
      s5_part_r <= s5_part_nxt;
      s5_tot_r  <= s4_tot_r;
    end
    if (rdy[5]) begin
      s6_rank_r <= s6_rank_nxt;
      s6_err_r  <= s6_err_nxt;
      s6_cnt_r  <= s5_tot_r;
    end
  end

  assign out_valid         = v_r[NST-1];
  assign out_rank          = s6_rank_r;
  assign out_too_many_bits = s6_err_r;
  assign out_bit_count     = s6_cnt_r;

  // Error beats carry a zero rank
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_many_bits |-> out_rank == '0)
    else $error("error beat with non-zero rank");

  // Good beats never carry a zero rank
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_too_many_bits |-> out_rank != '0)
    else $error("good beat with zero rank");

  // Error flag agrees with the delivered count
  a_err_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_too_many_bits == (out_bit_count > cnr_pkg::CNT_W'(MAX_SET)))
    else $error("error flag disagrees with bit count");

endmodule

[tb/combinadic_rank_checker.sv]
module combinadic_rank_checker #(
  parameter int MAX_SET = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [cnr_pkg::MASK_W-1:0]  in_card_mask,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [cnr_pkg::RANK_W-1:0]  out_rank,
  input  logic                        out_too_many_bits,
  input  logic [cnr_pkg::CNT_W-1:0]   out_bit_count,
  output int unsigned                 fail_count,
  output int unsigned                 pending
);

  typedef struct packed {
    cnr_pkg::rank_t rank;
    logic           too_many_bits;
    cnr_pkg::cnt_t  bit_count;
  } rank_result_t;

  // Ranks still owed by the block, oldest first
  rank_result_t rank_due_q[$];

  // C(n, k) by the multiplicative formula; every step divides exactly
  function automatic logic [63:0] binomial(int unsigned n, int unsigned k);
    logic [63:0] c;
    c = 64'd1;
    if (k > n) begin
      return 64'd0;
    end
    for (int unsigned j = 0; j < k; j++) begin
      c = (c * 64'(n - j)) / 64'(j + 1);
    end
    return c;
  endfunction

  // Walk the set bits upwards; the i-th one at position p adds C(p, i)
  function automatic rank_result_t predict_rank(logic [cnr_pkg::MASK_W-1:0] mask);
    rank_result_t r;
    logic [63:0]  sum;
    int unsigned  count;
    sum   = 64'd1;
    count = 0;
    for (int p = 0; p < cnr_pkg::MASK_W; p++) begin
      if (mask[p]) begin
        count++;
        if (count <= MAX_SET) begin
          sum += binomial(p, count);
        end
      end
    end
    if (count > MAX_SET) begin
      r.rank          = '0;
      r.too_many_bits = 1'b1;
    end else begin
      r.rank          = cnr_pkg::rank_t'(sum);
      r.too_many_bits = 1'b0;
    end
    r.bit_count = cnr_pkg::cnt_t'(count);
    return r;
  endfunction

  // Compare each result beat with the oldest prediction, then record new input beats
  always @(posedge clk) begin : track
    rank_result_t want;
    if (!rst_n) begin
      rank_due_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rank_due_q.size() == 0) begin
          $error("result beat with nothing due: rank %0d", out_rank);
          fail_count++;
        end else begin
          want = rank_due_q.pop_front();
          if (out_rank !== want.rank) begin
            $error("rank: expected %0d, got %0d", want.rank, out_rank);
            fail_count++;
          end
          if (out_too_many_bits !== want.too_many_bits) begin
            $error("too_many_bits: expected %0b, got %0b",
                   want.too_many_bits, out_too_many_bits);
            fail_count++;
          end
          if (out_bit_count !== want.bit_count) begin
            $error("bit_count: expected %0d, got %0d", want.bit_count, out_bit_count);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        rank_due_q.push_back(predict_rank(in_card_mask));
      end
    end
    pending <= rank_due_q.size();
  end

endmodule

[tb/tb_combinadic_rank_64bit_core.sv]
module tb_combinadic_rank_64bit_core;

  localparam int MAX_SET       = 7;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int RANDOM_PER_PH = 150;

  // Sender idle and receiver stall percentages per phase
  localparam int PHASE_IDLE[4]  = '{0, 61, 0, 37};
  localparam int PHASE_STALL[4] = '{0, 0, 61, 37};

  // Extremes, the seven-bit maximum and several over-full masks
  localparam logic [cnr_pkg::MASK_W-1:0] DIRECTED[20] = '{
    64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001,
    64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFE00_0000_0000_0000, 64'h0000_0000_0000_007F,
    64'h0000_0000_0000_00FF, 64'hFF00_0000_0000_0000,
    64'h8000_0000_0000_0001, 64'h4000_2000_1000_0801,
    64'h8040_2010_0804_0201, 64'h0040_2010_0804_0201,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
    64'h0000_0000_0000_0002, 64'h0000_0000_0000_0006,
    64'hFC00_0000_0000_0001, 64'hFE00_0000_0000_0001,
    64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF
  };

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [cnr_pkg::MASK_W-1:0]  in_card_mask;
  logic                        out_valid;
  logic                        out_ready;
  logic [cnr_pkg::RANK_W-1:0]  out_rank;
  logic                        out_too_many_bits;
  logic [cnr_pkg::CNT_W-1:0]   out_bit_count;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  combinadic_rank_64bit_core #(
    .MAX_SET(MAX_SET)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_card_mask     (in_card_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rank         (out_rank),
    .out_too_many_bits(out_too_many_bits),
    .out_bit_count    (out_bit_count)
  );

  combinadic_rank_checker #(
    .MAX_SET(MAX_SET)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_card_mask     (in_card_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rank         (out_rank),
    .out_too_many_bits(out_too_many_bits),
    .out_bit_count    (out_bit_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("combinadic_rank_64bit_core: mismatch");
      $finish;
    end
  end

  // Stall the result channel at the phase's rate; hold it low in reset
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Mostly legal masks of up to seven bits, some just over, some fully random
  function automatic logic [cnr_pkg::MASK_W-1:0] random_mask();
    logic [cnr_pkg::MASK_W-1:0] m;
    int unsigned                sel;
    int unsigned                want;
    int unsigned                lo;
    m   = '0;
    sel = $urandom_range(99);
    if (sel < 12) begin
      return {$urandom, $urandom};
    end
    want = (sel < 20) ? MAX_SET + 1 : $urandom_range(MAX_SET);
    lo   = ($urandom_range(3) == 0) ? 40 : 0;
    while ($countones(m) < want) begin
      m[$urandom_range(cnr_pkg::MASK_W - 1, lo)] = 1'b1;
    end
    return m;
  endfunction

  // Offer one beat, with an optional idle gap first; return once accepted
  task automatic send_mask(input logic [cnr_pkg::MASK_W-1:0] m);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_card_mask <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_card_mask  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = PHASE_IDLE[ph];
      stall_pct    <= PHASE_STALL[ph];
      if (ph == 0) begin
        foreach (DIRECTED[i]) begin
          send_mask(DIRECTED[i]);
        end
      end
      repeat (RANDOM_PER_PH) send_mask(random_mask());
    end
    in_valid <= 1'b0;

    // Drain outstanding ranks, then give the pipeline time to show strays
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);

    if (fail_count == 0) begin
      $display("combinadic_rank_64bit_core: match");
    end else begin
      $display("combinadic_rank_64bit_core: mismatch");
    end
    $finish;
  end

endmodule
